[design/scsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package scsc_pkg;

	// Character codes that the line parser and the reply path use.
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_S  = 8'h53;
	localparam logic [7:0] CH_N  = 8'h4E;
	localparam logic [7:0] CH_T  = 8'h54;
	localparam logic [7:0] CH_H  = 8'h48;
	localparam logic [7:0] CH_O  = 8'h4F;
	localparam logic [7:0] CH_K  = 8'h4B;

	// Position loaded when homing begins.
	localparam logic [15:0] HOME_START = 16'hFFFF;

	// One classified request as it travels from the front to the back.
	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        reply;
		logic        step_pulse;
		logic        step_forward;
		logic        motor_enable;
		logic        move_done;
		logic [15:0] numbers_us;
		logic [15:0] stamp_us;
	} entry_t;

endpackage

`default_nettype wire

[design/scsc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module scsc_front #(
	parameter int LINE_MAX = 250
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire                  kind,
	input  wire  [7:0]           rx_byte,
	input  wire                  end_hit,
	input  wire                  q_full,
	output logic                 push,
	output scsc_pkg::entry_t     push_entry
);

	localparam int LINE_W = $clog2(LINE_MAX + 1);

	logic [15:0]       pos_q, tgt_q, nw_q, sw_q, acc_q;
	logic              done_q, homing_q, enable_q, dir_q, digits_open_q;
	logic [LINE_W-1:0] line_pos_q;
	logic [7:0]        letter_q;

	logic [15:0]       pos_d, tgt_d, nw_d, sw_d, acc_d;
	logic              done_d, homing_d, enable_d, dir_d, digits_open_d;
	logic [LINE_W-1:0] line_pos_d;
	logic [7:0]        letter_d;
	logic              pulse, reply, forward;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// Next state for one request: a step tick or a received character.
	always_comb begin
		pos_d         = pos_q;
		tgt_d         = tgt_q;
		nw_d          = nw_q;
		sw_d          = sw_q;
		acc_d         = acc_q;
		done_d        = done_q;
		homing_d      = homing_q;
		enable_d      = enable_q;
		dir_d         = dir_q;
		digits_open_d = digits_open_q;
		line_pos_d    = line_pos_q;
		letter_d      = letter_q;
		pulse         = 1'b0;
		reply         = 1'b0;
		forward       = pos_q < tgt_q;
		if (kind) begin
			if (!done_q) begin
				if (homing_q && end_hit) begin
					enable_d = 1'b0;
					pos_d    = 16'd0;
					tgt_d    = 16'd0;
					homing_d = 1'b0;
					done_d   = 1'b1;
				end else if (pos_q == tgt_q) begin
					enable_d = 1'b0;
					done_d   = 1'b1;
				end else begin
					enable_d = 1'b1;
					if (!forward && end_hit) begin
						done_d = 1'b1;
					end else begin
						dir_d = forward;
						pos_d = forward ? pos_q + 16'd1 : pos_q - 16'd1;
						pulse = 1'b1;
					end
				end
			end
		end else if (rx_byte == scsc_pkg::CH_CR) begin
			// End of line: act on the command letter, then clear the parser.
			if (line_pos_q != '0) begin
				case (letter_q)
					scsc_pkg::CH_S: begin
						tgt_d  = acc_q;
						done_d = 1'b0;
						reply  = 1'b1;
					end
					scsc_pkg::CH_N: begin
						nw_d  = acc_q;
						reply = 1'b1;
					end
					scsc_pkg::CH_T: begin
						sw_d  = acc_q;
						reply = 1'b1;
					end
					scsc_pkg::CH_H: begin
						pos_d    = scsc_pkg::HOME_START;
						tgt_d    = 16'd0;
						done_d   = 1'b0;
						homing_d = 1'b1;
					end
					default: ;
				endcase
			end
			line_pos_d    = '0;
			letter_d      = 8'd0;
			acc_d         = 16'd0;
			digits_open_d = 1'b0;
		end else if (line_pos_q < LINE_W'(LINE_MAX)) begin
			// Characters past the line limit are echoed but not parsed.
			if (line_pos_q == '0) begin
				letter_d      = rx_byte;
				acc_d         = 16'd0;
				digits_open_d = 1'b1;
			end else if (digits_open_q) begin
				if (rx_byte inside {[scsc_pkg::CH_0:scsc_pkg::CH_9]}) begin
					acc_d = (acc_q << 3) + (acc_q << 1) + {12'd0, rx_byte[3:0]};
				end else begin
					digits_open_d = 1'b0;
				end
			end
			line_pos_d = line_pos_q + LINE_W'(1);
		end
	end

	// Request descriptor: echo, reply flag and the state after the request.
	always_comb begin
		push_entry.tx_valid     = !kind;
		push_entry.tx_byte      = kind ? 8'd0 : rx_byte;
		push_entry.reply        = reply;
		push_entry.step_pulse   = pulse;
		push_entry.step_forward = dir_d;
		push_entry.motor_enable = enable_d;
		push_entry.move_done    = done_d;
		push_entry.numbers_us   = nw_d;
		push_entry.stamp_us     = sw_d;
	end

	// Controller state; reset begins homing from the far end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= scsc_pkg::HOME_START;
			tgt_q         <= 16'd0;
			nw_q          <= 16'd0;
			sw_q          <= 16'd0;
			acc_q         <= 16'd0;
			done_q        <= 1'b0;
			homing_q      <= 1'b1;
			enable_q      <= 1'b0;
			dir_q         <= 1'b0;
			digits_open_q <= 1'b0;
			line_pos_q    <= '0;
			letter_q      <= 8'd0;
		end else if (push) begin
			pos_q         <= pos_d;
			tgt_q         <= tgt_d;
			nw_q          <= nw_d;
			sw_q          <= sw_d;
			acc_q         <= acc_d;
			done_q        <= done_d;
			homing_q      <= homing_d;
			enable_q      <= enable_d;
			dir_q         <= dir_d;
			digits_open_q <= digits_open_d;
			line_pos_q    <= line_pos_d;
			letter_q      <= letter_d;
		end
	end

endmodule

`default_nettype wire

[design/scsc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module scsc_queue #(
	parameter int DEPTH = 4
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  scsc_pkg::entry_t     push_entry,
	output logic                 full,
	input  wire                  pop,
	output logic                 not_empty,
	output scsc_pkg::entry_t     head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	scsc_pkg::entry_t  mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[design/scsc_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module scsc_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  q_not_empty,
	input  scsc_pkg::entry_t     q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic                 tx_valid,
	output logic [7:0]           tx_byte,
	output logic                 step_pulse,
	output logic                 step_forward,
	output logic                 motor_enable,
	output logic                 move_done,
	output logic [15:0]          numbers_servo_us,
	output logic [15:0]          stamp_servo_us,
	output logic                 last
);

	scsc_pkg::entry_t cur_q;
	logic             valid_q;
	logic [1:0]       idx_q;
	logic             take;

	// The final result is the echo alone, or the newline of an OK reply.
	assign last = !cur_q.reply || (idx_q == 2'd3);
	assign take = valid_q && out_ready;
	assign q_pop = q_not_empty && (!valid_q || (take && last));

	assign out_valid        = valid_q;
	assign tx_valid         = cur_q.tx_valid;
	assign step_pulse       = cur_q.step_pulse;
	assign step_forward     = cur_q.step_forward;
	assign motor_enable     = cur_q.motor_enable;
	assign move_done        = cur_q.move_done;
	assign numbers_servo_us = cur_q.numbers_us;
	assign stamp_servo_us   = cur_q.stamp_us;

	// Echo first, then the reply characters.
	always_comb begin
		case (idx_q)
			2'd1:    tx_byte = scsc_pkg::CH_O;
			2'd2:    tx_byte = scsc_pkg::CH_K;
			2'd3:    tx_byte = scsc_pkg::CH_LF;
			default: tx_byte = cur_q.tx_byte;
		endcase
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	// Output valid and result index within the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (take) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[design/serial_command_stepper_controller.sv]
// Serial command and stepper controller.
// Input channel (in_valid/in_ready) carries one request: a received serial
// byte (kind = 0, rx_byte) or a step timer tick (kind = 1), with the end
// switch level in end_hit. Output channel (out_valid/out_ready) carries the
// results: one per tick, one echo per byte, and after a carriage return that
// closes an S, N or T line three more bytes 'O', 'K', newline. The last flag
// marks the final result of a request; the motor and servo fields show the
// state after the request was handled.
// The front decodes and updates state in the cycle a request is accepted, so
// a request can be accepted every cycle while the queue has room. The first
// result of a request passes through the queue and then the output register
// before it is presented. The output side delivers one result per cycle
// while out_ready is high, so requests with a reply, which have four results
// each, limit the sustained request rate. When the receiver
// stalls, the output register holds and the queue of QUEUE_DEPTH requests
// fills before in_ready drops.
// Reset empties the queue, clears the parser and servo widths and starts
// homing from position 0xFFFF with the driver disabled.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_stepper_controller #(
	parameter int LINE_MAX    = 250,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         kind,
	input  wire  [7:0]  rx_byte,
	input  wire         end_hit,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        step_pulse,
	output logic        step_forward,
	output logic        motor_enable,
	output logic        move_done,
	output logic [15:0] numbers_servo_us,
	output logic [15:0] stamp_servo_us,
	output logic        last
);

	scsc_pkg::entry_t push_entry, head;
	logic             push, full, pop, not_empty;

	// Front: accepts and classifies requests, owns the controller state.
	scsc_front #(
		.LINE_MAX(LINE_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.rx_byte   (rx_byte),
		.end_hit   (end_hit),
		.q_full    (full),
		.push      (push),
		.push_entry(push_entry)
	);

	// Queue between front and back.
	scsc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	// Back: expands each request into its result bytes.
	scsc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_not_empty     (not_empty),
		.q_head          (head),
		.q_pop           (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.tx_valid        (tx_valid),
		.tx_byte         (tx_byte),
		.step_pulse      (step_pulse),
		.step_forward    (step_forward),
		.motor_enable    (motor_enable),
		.move_done       (move_done),
		.numbers_servo_us(numbers_servo_us),
		.stamp_servo_us  (stamp_servo_us),
		.last            (last)
	);

endmodule

`default_nettype wire

[design/scsc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module scsc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_ready,
	input wire        tx_valid,
	input wire [7:0]  tx_byte,
	input wire        step_pulse,
	input wire        step_forward,
	input wire        motor_enable,
	input wire        move_done,
	input wire [15:0] numbers_servo_us,
	input wire [15:0] stamp_servo_us,
	input wire        last
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable({tx_valid, tx_byte, step_pulse, step_forward, motor_enable,
				move_done, numbers_servo_us, stamp_servo_us, last}))
		else $error("result payload changed while stalled");

	// A tick result is the only result of its request and carries no byte.
	a_tick_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> last && tx_byte == 8'd0)
		else $error("tick result malformed");

	// A step is only issued with the driver on and a move in progress.
	a_step_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_pulse |-> motor_enable && !move_done)
		else $error("step while idle or disabled");

	// A result that is not the last is followed at once by a reply byte.
	a_reply_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=>
			out_valid && tx_valid &&
			(tx_byte == scsc_pkg::CH_O || tx_byte == scsc_pkg::CH_K ||
				tx_byte == scsc_pkg::CH_LF))
		else $error("reply sequence broken");

endmodule

bind serial_command_stepper_controller scsc_checker u_scsc_checker (.*);

`default_nettype wire

[tb/sv/tb_serial_command_stepper_controller.sv]
`timescale 1ns / 1ps

module tb_serial_command_stepper_controller;

	localparam int LINE_MAX = 250;
	localparam int RANDOM_PER_PHASE = 10;
	localparam int CYCLE_LIMIT = 400000;

	// Request kinds on the input channel.
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        step_pulse;
		logic        step_forward;
		logic        motor_enable;
		logic        move_done;
		logic [15:0] numbers_us;
		logic [15:0] stamp_us;
		logic        last;
	} ctrl_result_t;

	// One row of the directed script; typed rows carry their own expected result.
	typedef struct {
		logic         is_tick;
		logic [7:0]   ch;
		logic         end_sw;
		logic         typed;
		ctrl_result_t want;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        end_hit = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        step_pulse;
	logic        step_forward;
	logic        motor_enable;
	logic        move_done;
	logic [15:0] numbers_servo_us;
	logic [15:0] stamp_servo_us;
	logic        last;

	// Shadow of the controller state.
	logic [15:0] position;
	logic [15:0] goal;
	logic        move_finished;
	logic        homing_active;
	logic        driver_on;
	logic        heading_up;
	logic [15:0] numbers_width;
	logic [15:0] stamp_width;
	logic [7:0]  line_count;
	logic [7:0]  line_cmd;
	logic [15:0] line_value;
	logic        digits_live;

	ctrl_result_t step_out[$];
	ctrl_result_t awaited_results[$];
	ctrl_result_t head_result;
	script_row_t  script[$];

	int unsigned items_sent = 0;
	int unsigned mismatch_count = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	serial_command_stepper_controller #(
		.LINE_MAX(LINE_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.rx_byte(rx_byte),
		.end_hit(end_hit),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.step_pulse(step_pulse),
		.step_forward(step_forward),
		.motor_enable(motor_enable),
		.move_done(move_done),
		.numbers_servo_us(numbers_servo_us),
		.stamp_servo_us(stamp_servo_us),
		.last(last)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result as seen after the request was handled.
	function automatic ctrl_result_t snapshot(input logic valid, input logic [7:0] ch,
			input logic pulse);
		ctrl_result_t r;
		r.tx_valid = valid;
		r.tx_byte = ch;
		r.step_pulse = pulse;
		r.step_forward = heading_up;
		r.motor_enable = driver_on;
		r.move_done = move_finished;
		r.numbers_us = numbers_width;
		r.stamp_us = stamp_width;
		r.last = 1'b0;
		return r;
	endfunction

	// Single final result for rows whose outcome is known by hand; the servo
	// widths are still at their reset value in every such row.
	function automatic ctrl_result_t single_result(input logic valid, input logic [7:0] ch,
			input logic pulse, input logic fwd, input logic en, input logic done);
		ctrl_result_t r;
		r = '0;
		r.tx_valid = valid;
		r.tx_byte = ch;
		r.step_pulse = pulse;
		r.step_forward = fwd;
		r.motor_enable = en;
		r.move_done = done;
		r.last = 1'b1;
		return r;
	endfunction

	// Apply one request to the shadow state and collect the results it causes.
	function automatic void advance_controller(input logic is_tick, input logic [7:0] ch,
			input logic end_sw);
		logic pulse;
		logic up;
		logic reply;
		step_out.delete();
		pulse = 1'b0;
		reply = 1'b0;
		if (is_tick) begin
			if (!move_finished) begin
				if (homing_active && end_sw) begin
					driver_on = 1'b0;
					position = 16'h0000;
					goal = 16'h0000;
					homing_active = 1'b0;
					move_finished = 1'b1;
				end else if (position == goal) begin
					driver_on = 1'b0;
					move_finished = 1'b1;
				end else begin
					driver_on = 1'b1;
					up = position < goal;
					if (!up && end_sw) begin
						move_finished = 1'b1;
					end else begin
						heading_up = up;
						position = up ? position + 16'd1 : position - 16'd1;
						pulse = 1'b1;
					end
				end
			end
			step_out.push_back(snapshot(1'b0, 8'h00, pulse));
		end else if (ch == scsc_pkg::CH_CR) begin
			// A carriage return closes the line and acts on its command letter.
			if (line_count != 8'd0) begin
				case (line_cmd)
					scsc_pkg::CH_S: begin
						goal = line_value;
						move_finished = 1'b0;
						reply = 1'b1;
					end
					scsc_pkg::CH_N: begin
						numbers_width = line_value;
						reply = 1'b1;
					end
					scsc_pkg::CH_T: begin
						stamp_width = line_value;
						reply = 1'b1;
					end
					scsc_pkg::CH_H: begin
						position = scsc_pkg::HOME_START;
						goal = 16'h0000;
						move_finished = 1'b0;
						homing_active = 1'b1;
					end
					default: ;
				endcase
			end
			line_count = 8'd0;
			line_cmd = 8'h00;
			line_value = 16'h0000;
			digits_live = 1'b0;
			step_out.push_back(snapshot(1'b1, scsc_pkg::CH_CR, 1'b0));
			if (reply) begin
				step_out.push_back(snapshot(1'b1, scsc_pkg::CH_O, 1'b0));
				step_out.push_back(snapshot(1'b1, scsc_pkg::CH_K, 1'b0));
				step_out.push_back(snapshot(1'b1, scsc_pkg::CH_LF, 1'b0));
			end
		end else begin
			// Characters past the line limit are echoed but not parsed.
			if (line_count < LINE_MAX) begin
				if (line_count == 8'd0) begin
					line_cmd = ch;
					line_value = 16'h0000;
					digits_live = 1'b1;
				end else if (digits_live) begin
					if (ch >= scsc_pkg::CH_0 && ch <= scsc_pkg::CH_9)
						line_value = line_value * 16'd10 + 16'(ch - scsc_pkg::CH_0);
					else
						digits_live = 1'b0;
				end
				line_count = line_count + 8'd1;
			end
			step_out.push_back(snapshot(1'b1, ch, 1'b0));
		end
		step_out[step_out.size() - 1].last = 1'b1;
	endfunction

	function automatic void reset_controller();
		position = scsc_pkg::HOME_START;
		goal = 16'h0000;
		move_finished = 1'b0;
		homing_active = 1'b1;
		driver_on = 1'b0;
		heading_up = 1'b0;
		numbers_width = 16'h0000;
		stamp_width = 16'h0000;
		line_count = 8'd0;
		line_cmd = 8'h00;
		line_value = 16'h0000;
		digits_live = 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		$display("[%0t] result %0d: %s got %0h expected %0h", $time, results_seen, what,
			got, want);
	endtask

	task automatic compare_field(input string what, input longint got, input longint want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	// Drive one request, wait for acceptance, then record what it should cause.
	task automatic send_request(input logic req_kind, input logic [7:0] req_byte,
			input logic req_end, input logic has_want = 1'b0, input ctrl_result_t want = '0);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= req_kind;
		rx_byte <= req_byte;
		end_hit <= req_end;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_controller(req_kind, req_byte, req_end);
		if (has_want)
			awaited_results.push_back(want);
		else
			foreach (step_out[i])
				awaited_results.push_back(step_out[i]);
		items_sent++;
	endtask

	task automatic send_tick();
		send_request(KIND_TICK, 8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
	endtask

	// A serial byte, now and then preceded by a tick in the middle of a line.
	task automatic send_byte(input logic [7:0] ch);
		if ($urandom_range(0, 15) == 0)
			send_tick();
		send_request(KIND_BYTE, ch, 1'($urandom_range(0, 1)));
	endtask

	function automatic logic [7:0] non_digit();
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(0, 255));
		while ((ch >= scsc_pkg::CH_0 && ch <= scsc_pkg::CH_9) || ch == scsc_pkg::CH_CR);
		return ch;
	endfunction

	// Mostly well-formed command lines with random values, some broken ones.
	task automatic send_command_line();
		int unsigned pick;
		int unsigned value;
		string digits;
		logic [7:0] letter;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			letter = scsc_pkg::CH_S;
		else if (pick < 48)
			letter = scsc_pkg::CH_N;
		else if (pick < 66)
			letter = scsc_pkg::CH_T;
		else if (pick < 76)
			letter = scsc_pkg::CH_H;
		else if (pick < 90)
			letter = 8'($urandom_range(0, 255));
		else
			letter = scsc_pkg::CH_CR;
		if (letter == scsc_pkg::CH_S) begin
			// Targets near the current position so that moves reach them.
			if (position < 16'd12)
				value = position + $urandom_range(0, 12);
			else
				value = position + $urandom_range(0, 24) - 12;
		end else begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				value = $urandom_range(0, 65535);
			else if (pick < 9)
				value = $urandom_range(65536, 999999);
			else
				value = $urandom_range(0, 1) * 65535;
		end
		digits = $sformatf("%0d", value);
		if ($urandom_range(0, 4) == 0)
			digits = {"00", digits};
		if (letter == scsc_pkg::CH_H && $urandom_range(0, 3) != 0)
			digits = "";
		if (letter != scsc_pkg::CH_CR) begin
			send_byte(letter);
			for (int i = 0; i < digits.len(); i++) begin
				if ($urandom_range(0, 24) == 0)
					send_byte(non_digit());
				send_byte(digits[i]);
			end
			if ($urandom_range(0, 9) == 0)
				send_byte(non_digit());
		end
		send_byte(scsc_pkg::CH_CR);
	endtask

	task automatic send_random_burst();
		if ($urandom_range(0, 99) < 6)
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
		else
			send_command_line();
		repeat ($urandom_range(0, 10)) send_tick();
	endtask

	// A numbers line of digits running past the line limit.
	task automatic send_long_line();
		send_byte(scsc_pkg::CH_N);
		repeat (LINE_MAX + 6) send_byte(scsc_pkg::CH_0 + 8'($urandom_range(0, 9)));
		send_byte(scsc_pkg::CH_CR);
	endtask

	task automatic add_row(input logic is_tick, input logic [7:0] ch, input logic end_sw);
		script.push_back('{is_tick, ch, end_sw, 1'b0, ctrl_result_t'('0)});
	endtask

	task automatic add_typed_row(input logic is_tick, input logic [7:0] ch,
			input logic end_sw, input ctrl_result_t want);
		script.push_back('{is_tick, ch, end_sw, 1'b1, want});
	endtask

	// Output checker and random receiver stalls.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result, tx_byte", tx_byte, 0);
			end else begin
				head_result = awaited_results.pop_front();
				compare_field("tx_valid", tx_valid, head_result.tx_valid);
				compare_field("tx_byte", tx_byte, head_result.tx_byte);
				compare_field("step_pulse", step_pulse, head_result.step_pulse);
				compare_field("step_forward", step_forward, head_result.step_forward);
				compare_field("motor_enable", motor_enable, head_result.motor_enable);
				compare_field("move_done", move_done, head_result.move_done);
				compare_field("numbers_servo_us", numbers_servo_us, head_result.numbers_us);
				compare_field("stamp_servo_us", stamp_servo_us, head_result.stamp_us);
				compare_field("last", last, head_result.last);
			end
		end
		out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("serial_command_stepper_controller verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned phase_start;
		reset_controller();

		// Homing after reset, homing end, idle tick, empty and unknown lines.
		add_typed_row(KIND_TICK, 8'h00, 1'b0, single_result(0, 8'h00, 1, 0, 1, 0));
		add_typed_row(KIND_TICK, 8'h00, 1'b1, single_result(0, 8'h00, 0, 0, 0, 1));
		add_typed_row(KIND_TICK, 8'h00, 1'b0, single_result(0, 8'h00, 0, 0, 0, 1));
		add_typed_row(KIND_BYTE, scsc_pkg::CH_CR, 1'b0,
			single_result(1, scsc_pkg::CH_CR, 0, 0, 0, 1));
		add_typed_row(KIND_BYTE, 8'hFF, 1'b1, single_result(1, 8'hFF, 0, 0, 0, 1));
		add_typed_row(KIND_BYTE, 8'h00, 1'b0, single_result(1, 8'h00, 0, 0, 0, 1));
		add_typed_row(KIND_BYTE, scsc_pkg::CH_CR, 1'b0,
			single_result(1, scsc_pkg::CH_CR, 0, 0, 0, 1));
		// Move line whose number is cut short by a non-digit.
		add_typed_row(KIND_BYTE, scsc_pkg::CH_S, 1'b0,
			single_result(1, scsc_pkg::CH_S, 0, 0, 0, 1));
		add_row(KIND_BYTE, scsc_pkg::CH_0 + 8'd1, 1'b0);
		add_row(KIND_BYTE, scsc_pkg::CH_9 + 8'd1, 1'b0);
		add_row(KIND_BYTE, scsc_pkg::CH_9, 1'b0);
		add_row(KIND_BYTE, scsc_pkg::CH_CR, 1'b0);
		// One forward step, then arrival at the target.
		add_row(KIND_TICK, 8'h00, 1'b0);
		add_row(KIND_TICK, 8'h00, 1'b0);
		// Numbers width with a value that wraps.
		add_row(KIND_BYTE, scsc_pkg::CH_N, 1'b0);
		repeat (5) add_row(KIND_BYTE, scsc_pkg::CH_9, 1'b0);
		add_row(KIND_BYTE, scsc_pkg::CH_CR, 1'b0);
		// Stamp width.
		add_row(KIND_BYTE, scsc_pkg::CH_T, 1'b0);
		add_row(KIND_BYTE, scsc_pkg::CH_0 + 8'd5, 1'b0);
		add_row(KIND_BYTE, scsc_pkg::CH_CR, 1'b0);
		// Move back to zero, stopped by the end switch.
		add_row(KIND_BYTE, scsc_pkg::CH_S, 1'b0);
		add_row(KIND_BYTE, scsc_pkg::CH_CR, 1'b0);
		add_row(KIND_TICK, 8'h00, 1'b1);
		// Homing command.
		add_row(KIND_BYTE, scsc_pkg::CH_H, 1'b0);
		add_row(KIND_BYTE, scsc_pkg::CH_CR, 1'b0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles lightly, receiver stalls heavily.
		send_idle_pct = 25;
		recv_idle_pct = 83;
		foreach (script[i])
			send_request(script[i].is_tick, script[i].ch, script[i].end_sw, script[i].typed,
				script[i].want);
		phase_start = items_sent;
		while (items_sent - phase_start < RANDOM_PER_PHASE)
			send_random_burst();

		// Hold the sender until every pending result has drained.
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);

		// Sender idles heavily, receiver stalls lightly.
		send_idle_pct = 83;
		recv_idle_pct = 25;
		phase_start = items_sent;
		while (items_sent - phase_start < RANDOM_PER_PHASE)
			send_random_burst();

		// Full throughput on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_long_line();
		phase_start = items_sent;
		while (items_sent - phase_start < RANDOM_PER_PHASE)
			send_random_burst();

		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0)
			$display("serial_command_stepper_controller verification clean");
		else
			$display("serial_command_stepper_controller verification failed");
		$finish;
	end

endmodule

[serial_command_stepper_controller.f]
design/scsc_pkg.sv
design/scsc_front.sv
design/scsc_queue.sv
design/scsc_back.sv
design/serial_command_stepper_controller.sv
design/scsc_checker.sv
tb/sv/tb_serial_command_stepper_controller.sv
